[hw/rtl/assert_macros.svh]
// Assertion macros used by the RTL top level of the cluster table engine.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/fct_pkg.sv]
// Shared types and constants for the FAT16 cluster table engine.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 4096;
	localparam int unsigned CNT_W             = 12;
	localparam logic [CNT_W-1:0] COUNT_RESET  = 12'd4094;

	localparam logic [15:0] END_OF_CHAIN  = 16'hFFFF;
	localparam logic [15:0] CHAIN_END_MIN = 16'hFFF8;
	localparam logic [15:0] FIRST_DATA    = 16'd2;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_NEXT  = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] cluster;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] cluster_out;
	} rsp_t;

	typedef enum logic [1:0] {CUR_HOLD, CUR_FIRST, CUR_INC, CUR_LINK} cur_sel_t;
	typedef enum logic [1:0] {RD_CUR, RD_PREV, RD_NEXT, RD_LINK} rd_sel_t;
	typedef enum logic [1:0] {WA_CUR, WA_PREV, WA_CLR} wa_sel_t;
	typedef enum logic [1:0] {WD_ZERO, WD_EOC, WD_CUR} wd_sel_t;
	typedef enum logic [1:0] {RES_ZERO, RES_CUR, RES_RD} res_sel_t;

	typedef struct packed {
		logic       load;
		cur_sel_t   cur_sel;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       wr_en;
		wa_sel_t    wa_sel;
		wd_sel_t    wd_sel;
		logic       clr_adv;
		logic       res_load;
		logic [1:0] res_status;
		res_sel_t   res_sel;
		logic       out_push;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       prev_zero;
		logic       prev_data;
		logic       cur_data;
		logic       cur_last;
		logic       rd_zero;
		logic       rd_end;
		logic       link_data;
		logic       link_self;
		logic       clr_done;
		logic       slot_free;
	} stat_t;

endpackage

`default_nettype wire

[hw/rtl/fat16_cluster_table_engine_top.sv]
// FAT16 cluster table engine: top level joining controller and datapath.
// Depends on fct_pkg, fct_ctrl, fct_datapath and assert_macros.svh.
//
// Usage:
//   Request channel (req_valid, req_stall, req): one transfer carries an
//   operation (allocate, free chain, read next link) and a cluster number.
//   Response channel (rsp_valid, rsp_stall, rsp): exactly one transfer per
//   request, carrying a status and a cluster number.
//   Configuration channel (cfg_valid, cfg_ready, cfg_data): writes the data
//   cluster count; always ready, write only while no request is in flight.
// From request transfer to response, one request at a time: a request settled
//   at decode goes straight to the response state; next link reads the entry;
//   free chain reads one entry after another; allocate checks a previous
//   cluster if given, scans entries and links the previous one to the new
//   cluster. A new request is taken once the result is in the output slot.
// Reset clears the controller and loads the count of 4094, then runs a
// clearing pass over every table entry with req_stall high.
// A response held by rsp_stall waits in the output register; the next
// request is still taken and worked, and its result waits for the slot.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fat16_cluster_table_engine_top #(
	parameter int unsigned TABLE_ENTRIES = fct_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      req_valid,
	output logic                           req_stall,
	input  wire fct_pkg::req_t             req,
	output logic                           rsp_valid,
	input  wire logic                      rsp_stall,
	output fct_pkg::rsp_t                  rsp,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [fct_pkg::CNT_W-1:0] cfg_data
);
	import fct_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  rsp_err;
	logic  rsp_code_ok;
	logic  req_take;

	// The count register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	fct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	fct_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

	assign rsp_err     = rsp_valid && (rsp.status != ST_OK);
	assign rsp_code_ok = (rsp.status == ST_OK) || (rsp.status == ST_FULL)
		|| (rsp.status == ST_BAD);
	assign req_take    = req_valid && !req_stall;

	// Only an ok response carries a cluster number.
	`CHK_IMPLY(a_rsp_zero, clk, arst_n, rsp_err, rsp.cluster_out == '0, "error with cluster")

	// Status codes stay within ok, full and bad.
	`CHK_IMPLY(a_rsp_code, clk, arst_n, rsp_valid, rsp_code_ok, "unknown response status")

	// No table write while the engine is open for a request.
	`CHK_IMPLY(a_idle_nowr, clk, arst_n, !req_stall, !cmd.wr_en, "table write while idle")

	// A request transfer closes the input until its response is produced.
	`CHK_NEXT(a_accept_busy, clk, arst_n, req_take, req_stall, "request accepted while busy")

endmodule

`default_nettype wire

[hw/rtl/fct_datapath.sv]
// Datapath: link table memory, cluster registers, count register, result and output registers.
// Depends on fct_pkg; driven by fct_ctrl through cmd_t, reports through stat_t.
`timescale 1ns / 1ps
`default_nettype none

module fct_datapath #(
	parameter int unsigned TABLE_ENTRIES = fct_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire fct_pkg::req_t            req,
	output fct_pkg::rsp_t                 rsp,
	output logic                          rsp_valid,
	input  wire logic                     rsp_stall,
	input  wire logic                     cfg_valid,
	input  wire logic [fct_pkg::CNT_W-1:0] cfg_data,
	input  wire fct_pkg::cmd_t            cmd,
	output fct_pkg::stat_t                stat
);
	import fct_pkg::*;

	localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [16:0] LAST_MAX = 17'(TABLE_ENTRIES - 1);
	localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(TABLE_ENTRIES - 1);

	logic [15:0]      mem [TABLE_ENTRIES];
	logic [15:0]      rd_data_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       op_q;
	logic [15:0]      prev_q;
	logic [15:0]      cur_q;
	logic [IDX_W-1:0] clr_q;
	rsp_t             res_q;
	rsp_t             out_q;
	logic             out_valid_q;

	logic [16:0]      cnt_plus;
	logic [16:0]      last;
	logic [15:0]      rd_idx;
	logic [15:0]      wr_idx;
	logic [IDX_W-1:0] wr_addr;
	logic [15:0]      wr_data;
	logic [15:0]      res_val;

	// Last data cluster: count plus one, clipped to the table.
	assign cnt_plus = {{(17 - CNT_W){1'b0}}, count_q} + 17'd1;
	assign last     = (cnt_plus > LAST_MAX) ? LAST_MAX : cnt_plus;

	function automatic logic is_data(input logic [15:0] c, input logic [16:0] lst);
		return (c >= FIRST_DATA) && ({1'b0, c} <= lst);
	endfunction

	always_comb begin
		case (cmd.rd_sel)
			RD_CUR:  rd_idx = cur_q;
			RD_PREV: rd_idx = prev_q;
			RD_NEXT: rd_idx = cur_q + 16'd1;
			RD_LINK: rd_idx = rd_data_q;
			default: rd_idx = cur_q;
		endcase
	end

	always_comb begin
		case (cmd.wa_sel)
			WA_CUR:  wr_idx = cur_q;
			WA_PREV: wr_idx = prev_q;
			WA_CLR:  wr_idx = 16'(clr_q);
			default: wr_idx = cur_q;
		endcase
		wr_addr = wr_idx[IDX_W-1:0];
		case (cmd.wd_sel)
			WD_ZERO: wr_data = '0;
			WD_EOC:  wr_data = END_OF_CHAIN;
			WD_CUR:  wr_data = cur_q;
			default: wr_data = '0;
		endcase
		case (cmd.res_sel)
			RES_ZERO: res_val = '0;
			RES_CUR:  res_val = cur_q;
			RES_RD:   res_val = rd_data_q;
			default:  res_val = '0;
		endcase
	end

	// Table memory: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_idx[IDX_W-1:0]];
		end
	end

	// Item payload and result holding registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req.operation;
			prev_q <= req.cluster;
		end
		if (cmd.load) begin
			cur_q <= req.cluster;
		end else begin
			case (cmd.cur_sel)
				CUR_FIRST: cur_q <= FIRST_DATA;
				CUR_INC:   cur_q <= cur_q + 16'd1;
				CUR_LINK:  cur_q <= rd_data_q;
				default:   cur_q <= cur_q;
			endcase
		end
		if (cmd.res_load) begin
			res_q.status      <= cmd.res_status;
			res_q.cluster_out <= res_val;
		end
		if (cmd.out_push) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= COUNT_RESET;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				count_q <= cfg_data;
			end
			if (cmd.clr_adv) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.out_push) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp       = out_q;
	assign rsp_valid = out_valid_q;

	always_comb begin
		stat.op        = op_q;
		stat.prev_zero = (prev_q == '0);
		stat.prev_data = is_data(prev_q, last);
		stat.cur_data  = is_data(cur_q, last);
		stat.cur_last  = ({1'b0, cur_q} == last);
		stat.rd_zero   = (rd_data_q == '0);
		stat.rd_end    = (rd_data_q >= CHAIN_END_MIN);
		stat.link_data = is_data(rd_data_q, last);
		stat.link_self = (rd_data_q == cur_q);
		stat.clr_done  = (clr_q == CLR_LAST);
		stat.slot_free = !out_valid_q || !rsp_stall;
	end

endmodule

`default_nettype wire

[hw/rtl/fct_ctrl.sv]
// Controller state machine: sequences the clear pass, allocate scan, chain walk and lookup.
// Depends on fct_pkg; drives fct_datapath through cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module fct_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire fct_pkg::stat_t stat,
	output fct_pkg::cmd_t       cmd
);
	import fct_pkg::*;

	typedef enum logic [9:0] {
		S_CLEAR     = 10'b0000000001,
		S_IDLE      = 10'b0000000010,
		S_DECODE    = 10'b0000000100,
		S_ALC_PREV  = 10'b0000001000,
		S_ALC_START = 10'b0000010000,
		S_ALC_SCAN  = 10'b0000100000,
		S_ALC_LINK  = 10'b0001000000,
		S_FREE_CHK  = 10'b0010000000,
		S_NEXT_RD   = 10'b0100000000,
		S_RESP      = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.cur_sel    = CUR_HOLD;
		cmd.rd_sel     = RD_CUR;
		cmd.wa_sel     = WA_CUR;
		cmd.wd_sel     = WD_ZERO;
		cmd.res_status = ST_BAD;
		cmd.res_sel    = RES_ZERO;
		unique case (state_q)
			S_CLEAR: begin
				cmd.wr_en   = 1'b1;
				cmd.wa_sel  = WA_CLR;
				cmd.clr_adv = 1'b1;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				// prev and cur both hold the request cluster here
				unique case (stat.op)
					OP_ALLOC: begin
						if (!stat.prev_zero) begin
							if (stat.prev_data) begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RD_PREV;
								state_d    = S_ALC_PREV;
							end else begin
								cmd.res_load = 1'b1;
								state_d      = S_RESP;
							end
						end else begin
							cmd.cur_sel = CUR_FIRST;
							state_d     = S_ALC_START;
						end
					end
					OP_FREE: begin
						if (stat.prev_zero) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_OK;
							state_d        = S_RESP;
						end else if (stat.cur_data) begin
							cmd.rd_en = 1'b1;
							state_d   = S_FREE_CHK;
						end else begin
							cmd.res_load = 1'b1;
							state_d      = S_RESP;
						end
					end
					OP_NEXT: begin
						if (stat.cur_data) begin
							cmd.rd_en = 1'b1;
							state_d   = S_NEXT_RD;
						end else begin
							cmd.res_load = 1'b1;
							state_d      = S_RESP;
						end
					end
					default: begin
						cmd.res_load = 1'b1;
						state_d      = S_RESP;
					end
				endcase
			end
			S_ALC_PREV: begin
				if (stat.rd_zero) begin
					cmd.res_load = 1'b1;
					state_d      = S_RESP;
				end else begin
					cmd.cur_sel = CUR_FIRST;
					state_d     = S_ALC_START;
				end
			end
			S_ALC_START: begin
				// a zero count leaves cur above last: report full
				if (!stat.cur_data) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_FULL;
					state_d        = S_RESP;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_ALC_SCAN;
				end
			end
			S_ALC_SCAN: begin
				if (stat.rd_zero) begin
					cmd.wr_en  = 1'b1;
					cmd.wd_sel = WD_EOC;
					if (stat.prev_zero) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_OK;
						cmd.res_sel    = RES_CUR;
						state_d        = S_RESP;
					end else begin
						state_d = S_ALC_LINK;
					end
				end else if (stat.cur_last) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_FULL;
					state_d        = S_RESP;
				end else begin
					cmd.cur_sel = CUR_INC;
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RD_NEXT;
				end
			end
			S_ALC_LINK: begin
				cmd.wr_en      = 1'b1;
				cmd.wa_sel     = WA_PREV;
				cmd.wd_sel     = WD_CUR;
				cmd.res_load   = 1'b1;
				cmd.res_status = ST_OK;
				cmd.res_sel    = RES_CUR;
				state_d        = S_RESP;
			end
			S_FREE_CHK: begin
				if (stat.rd_zero) begin
					cmd.res_load = 1'b1;
					state_d      = S_RESP;
				end else begin
					cmd.wr_en = 1'b1;
					if (stat.rd_end) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = ST_OK;
						state_d        = S_RESP;
					end else if (!stat.link_data || stat.link_self) begin
						// a self link would find its own entry already zeroed
						cmd.res_load = 1'b1;
						state_d      = S_RESP;
					end else begin
						cmd.cur_sel = CUR_LINK;
						cmd.rd_en   = 1'b1;
						cmd.rd_sel  = RD_LINK;
					end
				end
			end
			S_NEXT_RD: begin
				cmd.res_load   = 1'b1;
				cmd.res_status = ST_OK;
				cmd.res_sel    = RES_RD;
				state_d        = S_RESP;
			end
			S_RESP: begin
				if (stat.slot_free) begin
					cmd.out_push = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[test/fct_table_monitor.sv]
// Passive monitor for the FAT16 cluster table engine: keeps a shadow link table,
// predicts each response and compares it with what the engine returns.
// Depends on fct_pkg for the request and response types and constants.
`timescale 1ns / 1ps

module fct_table_monitor
	import fct_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_stall,
	input  req_t             req,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  rsp_t             rsp,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	output int               mismatches,
	output int               outstanding
);

	logic [15:0]      shadow_links [TABLE_ENTRIES];
	logic [CNT_W-1:0] shadow_count;
	rsp_t             due_replies [$];
	int               faults;

	function automatic int last_cluster();
		int last;
		last = int'(shadow_count) + 1;
		if (last > int'(TABLE_ENTRIES) - 1)
			last = int'(TABLE_ENTRIES) - 1;
		return last;
	endfunction

	function automatic bit holds_data(int c);
		return c >= int'(FIRST_DATA) && c <= last_cluster() && shadow_count != '0;
	endfunction

	// Apply one request to the shadow table and return the response it earns.
	function automatic rsp_t apply_request(req_t r);
		rsp_t res;
		int   c;
		int   nxt;
		int   k;
		int   steps;
		int   last;
		bit   settled;
		res.status      = ST_BAD;
		res.cluster_out = '0;
		c       = int'(r.cluster);
		last    = last_cluster();
		settled = 1'b0;
		case (r.operation)
		OP_ALLOC: begin
			if (c != 0 && (!holds_data(c) || shadow_links[c] == '0)) begin
				res.status = ST_BAD;
			end else begin
				res.status = ST_FULL;
				if (shadow_count != '0) begin
					for (k = int'(FIRST_DATA); k <= last && !settled; k++) begin
						if (shadow_links[k] == '0) begin
							shadow_links[k] = END_OF_CHAIN;
							if (c != 0)
								shadow_links[c] = 16'(k);
							res.status      = ST_OK;
							res.cluster_out = 16'(k);
							settled         = 1'b1;
						end
					end
				end
			end
		end
		OP_FREE: begin
			if (c == 0) begin
				res.status = ST_OK;
			end else begin
				// a revisited cluster reads as zero, so a loop ends as a broken chain
				for (steps = 0; steps < int'(TABLE_ENTRIES) && !settled; steps++) begin
					if (!holds_data(c)) begin
						settled = 1'b1;
					end else begin
						nxt = int'(shadow_links[c]);
						if (nxt == 0) begin
							settled = 1'b1;
						end else begin
							shadow_links[c] = '0;
							if (nxt >= int'(CHAIN_END_MIN)) begin
								res.status = ST_OK;
								settled    = 1'b1;
							end else begin
								c = nxt;
							end
						end
					end
				end
			end
		end
		OP_NEXT: begin
			if (holds_data(c)) begin
				res.status      = ST_OK;
				res.cluster_out = shadow_links[c];
			end
		end
		default: ;
		endcase
		if (res.status != ST_OK)
			res.cluster_out = '0;
		return res;
	endfunction

	task automatic note_fault(string field, int wanted, int seen);
		$error("%s: expected %0d, actual %0d", field, wanted, seen);
		faults++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < int'(TABLE_ENTRIES); i++)
				shadow_links[i] = '0;
			shadow_count = COUNT_RESET;
			due_replies.delete();
			faults = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (due_replies.size() == 0) begin
					note_fault("unexpected response status", -1, int'(rsp.status));
				end else begin
					want = due_replies.pop_front();
					if (rsp.status !== want.status)
						note_fault("status", int'(want.status), int'(rsp.status));
					if (rsp.cluster_out !== want.cluster_out)
						note_fault("cluster_out", int'(want.cluster_out),
							int'(rsp.cluster_out));
				end
			end
			if (req_valid && !req_stall)
				due_replies.push_back(apply_request(req));
			if (cfg_valid && cfg_ready)
				shadow_count = cfg_data;
			mismatches  <= faults;
			outstanding <= due_replies.size();
		end
	end

endmodule

[test/testbench.sv]
// Top of the cluster table engine testbench: clock, reset, request and
// configuration stimulus, response back-pressure, watchdog and verdict.
// Depends on fct_pkg, fat16_cluster_table_engine_top and fct_table_monitor.
`timescale 1ns / 1ps

module testbench;
	import fct_pkg::*;

	// The request field allows a fourth operation code; the engine must reject it.
	localparam logic [1:0] OP_RESERVED = 2'd3;

	// Longest legal silence: the clearing pass after reset, or a full-table
	// scan or chain walk, plus a long receiver stall.
	localparam int QUIET_LIMIT   = 40000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASES        = 14;
	localparam int PHASE_ITEMS   = 95;
	localparam int LAST_INDEX    = TABLE_ENTRIES_DEF - 1;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_t             req       = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data  = '0;

	int          mismatches;
	int          outstanding;
	int          quiet_cycles = 0;
	int          burst_left   = 0;
	int          cur_count    = int'(COUNT_RESET);
	stall_mode_t stall_mode   = STALL_NONE;
	int          stall_left   = 0;
	int          stall_tick   = 0;

	// Cluster counts per phase: mostly small tables so that they fill up,
	// with the zero count, the top of the range and the 12-bit maximum mixed in.
	int phase_counts [PHASES] = '{1, 0, 2, 5, 16, 4095, 33, 64, 12, 4094, 200, 9, 3, 48};

	fat16_cluster_table_engine_top i_dut (.*);

	fct_table_monitor i_monitor (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver back-pressure: switch to a randomly picked stall pattern each time
	// the current one runs out, so that runs with no stalls alternate with heavy ones.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(50, 300);
		end
		stall_left--;
		stall_tick++;
		case (stall_mode)
		STALL_NONE:  rsp_stall <= 1'b0;
		STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
		STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 1);
		default:     rsp_stall <= ((stall_tick % 7) < 3);
		endcase
	end

	// Watchdog: count cycles without any transfer on any channel.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one request and hold it until the engine takes it. Requests go
	// out in bursts of random length; before each burst, drop valid for a
	// random gap, or for none at all so that back-to-back stretches occur.
	task automatic drive_item(input logic [1:0] op, input logic [15:0] cl);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= '{operation: op, cluster: cl};
		do @(posedge clk); while (req_stall);
	endtask

	// Hold the request channel idle until every predicted response has arrived.
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
	endtask

	// Write the cluster count with the engine idle; let it settle first.
	task automatic write_count(input int value);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= CNT_W'(value);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_count = value;
	endtask

	// Random request: mostly clusters inside the data range, and weighted to
	// its low end where first-fit allocation keeps the live chains, so that
	// links, frees and lookups land on allocated entries. The rest is noise:
	// zero, the reserved and end marks, just past the range, any 16-bit value.
	function automatic req_t pick_request();
		req_t r;
		int   roll;
		int   last;
		int   hi;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			r.operation = OP_ALLOC;
		else if (roll < 65)
			r.operation = OP_FREE;
		else if (roll < 95)
			r.operation = OP_NEXT;
		else
			r.operation = OP_RESERVED;
		last = (cur_count + 1 > LAST_INDEX) ? LAST_INDEX : cur_count + 1;
		roll = $urandom_range(0, 99);
		if (r.operation == OP_ALLOC && $urandom_range(0, 2) == 0)
			r.cluster = '0;
		else if (roll < 6)
			r.cluster = '0;
		else if (roll < 12)
			r.cluster = 16'hFFF0 + 16'($urandom_range(0, 15));
		else if (roll < 22 || cur_count == 0)
			r.cluster = 16'($urandom_range(0, 65535));
		else if (roll < 27)
			r.cluster = 16'(last + 1);
		else begin
			hi = (roll < 40 || last < 42) ? last : 42;
			r.cluster = 16'($urandom_range(2, hi));
		end
		return r;
	endfunction

	initial begin
		req_t pick;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset count of 4094, table empty.
		drive_item(OP_NEXT, 16'd2);            // first data cluster, free
		drive_item(OP_NEXT, 16'd4095);         // last data cluster
		drive_item(OP_NEXT, 16'd4096);         // just past the table
		drive_item(OP_NEXT, 16'd1);            // reserved low index
		drive_item(OP_NEXT, 16'hFFFF);
		drive_item(OP_ALLOC, 16'd0);           // new file: gets 2
		drive_item(OP_ALLOC, 16'd2);           // extend: 3, links 2 to 3
		drive_item(OP_ALLOC, 16'd3);           // extend: 4
		drive_item(OP_NEXT, 16'd2);            // reads the link to 3
		drive_item(OP_ALLOC, 16'd1);           // previous not a data cluster
		drive_item(OP_ALLOC, 16'd7);           // previous is free
		drive_item(OP_ALLOC, 16'hFFF7);        // bad-cluster mark as previous
		drive_item(OP_RESERVED, 16'hFFFF);     // unknown operation
		drive_item(OP_RESERVED, 16'd0);
		drive_item(OP_FREE, 16'd0);            // empty file
		drive_item(OP_FREE, 16'hFFF0);         // reserved mark as start
		drive_item(OP_FREE, 16'd9);            // start entry is free
		drive_item(OP_FREE, 16'd3);            // frees 3 and 4
		drive_item(OP_FREE, 16'd2);            // 2 cleared, then 3 is free: broken
		drive_item(OP_NEXT, 16'd2);
		drive_item(OP_ALLOC, 16'd4095);        // free previous at the top end
		drive_item(OP_FREE, 16'd65535);

		// Random phases, each under its own cluster count.
		for (int p = 0; p < PHASES; p++) begin
			write_count(phase_counts[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// once mid-phase, stop sending until the engine has answered everything
				if (p == 3 && i == PHASE_ITEMS / 2)
					drain();
				pick = pick_request();
				drive_item(pick.operation, pick.cluster);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
